// ===== hdl/ofb_pkg.sv =====
// shared constants and controller/datapath interface types for the block framer
`timescale 1ns / 1ps
`default_nettype none

package ofb_pkg;

    localparam int DEF_MAX_BLOCK   = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // fixed field widths
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = 6;
    localparam int REAL_W    = 7;
    localparam int IDX_W     = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_LENGTH   = 1'b1;

    localparam logic [CFG_W-1:0] BLOCK_LENGTH_RST = 7'd64;
    localparam logic [CFG_W-1:0] HOP_LENGTH_RST   = 7'd32;

    // input command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic take;
        logic issue;
    } ofb_cmd_t;

    typedef struct packed {
        logic block_go;
        logic slot_free;
        logic issue_last;
    } ofb_status_t;

endpackage

`default_nettype wire

// ===== hdl/overlapping_block_framer.sv =====
// top level of the overlapping block framer: controller plus ring datapath
// readout: a block-completing transfer starts the emit state, where each sample is
// read from the ring, then registered to the output; only such items stall input,
// until the single read port has read the block, one sample a cycle unless stalled
// reset: pointers, fill and block counter clear, block_length 64, hop_length 32;
// ring contents are not cleared and there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module overlapping_block_framer
    import ofb_pkg::*;
#(
    parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [CFG_W-1:0]       cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed      [SAMPLE_BITS-1:0] sample_out,
    output logic             [POS_W-1:0]       position,
    output logic             [REAL_W-1:0]      real_count,
    output logic             [IDX_W-1:0]       block_index,
    output logic                               last_of_block,
    output logic                               end_of_data
);

    ofb_cmd_t    ctl;
    ofb_status_t sts;

    ofb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    ofb_datapath #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sample_in     (sample_in),
        .ctl           (ctl),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .position      (position),
        .real_count    (real_count),
        .block_index   (block_index),
        .last_of_block (last_of_block),
        .end_of_data   (end_of_data)
    );

endmodule

`default_nettype wire

// ===== hdl/ofb_ram.sv =====
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ofb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ofb_ctrl.sv =====
// control state machine of the block framer: input acceptance and read sequencing
`timescale 1ns / 1ps
`default_nettype none

module ofb_ctrl
    import ofb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire ofb_status_t sts,
    output ofb_cmd_t         ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign ctl.take  = in_valid && (state_reg == ST_IDLE);
    assign ctl.issue = (state_reg == ST_EMIT) && sts.slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.take && sts.block_go)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (ctl.issue && sts.issue_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_take_while_issuing: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> !ctl.issue)
        else $error("input transfer during block readout");

    a_block_closes_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.take && sts.block_go) |=> in_stall)
        else $error("input not stalled after block start");

    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.issue && sts.issue_last) |=> !in_stall)
        else $error("input not reopened after final read");

endmodule

`default_nettype wire

// ===== hdl/ofb_datapath.sv =====
// ring store, fill tracking, read pipeline and output register of the block framer
`timescale 1ns / 1ps
`default_nettype none

module ofb_datapath
    import ofb_pkg::*;
#(
    parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [CFG_W-1:0]       cfg_data,
    input  wire logic                          cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire ofb_cmd_t                      ctl,
    output ofb_status_t                        sts,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed      [SAMPLE_BITS-1:0] sample_out,
    output logic             [POS_W-1:0]       position,
    output logic             [REAL_W-1:0]      real_count,
    output logic             [IDX_W-1:0]       block_index,
    output logic                               last_of_block,
    output logic                               end_of_data
);

    localparam int AW    = $clog2(MAX_BLOCK);
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SW    = CNT_W + 1;
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

    // modular add on ring pointers, n never exceeds the ring depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                               input logic [CNT_W-1:0] n);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(n);
        if (s >= SW'(MAX_BLOCK))
        begin
            s = s - SW'(MAX_BLOCK);
        end
        return AW'(s);
    endfunction

    logic [CFG_W-1:0] blk_len_reg, blk_len_next;
    logic [CFG_W-1:0] hop_len_reg, hop_len_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    bs_reg, bs_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] real_reg, real_next;
    logic [CNT_W-1:0] pos_cnt_reg, pos_cnt_next;
    logic             final_reg, final_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             out_valid_reg;

    logic [CNT_W-1:0] s1_pos_reg;
    logic [CNT_W-1:0] s1_real_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_pad_reg;
    logic             s1_last_reg;
    logic             s1_eod_reg;

    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic [POS_W-1:0]              position_reg;
    logic [REAL_W-1:0]             real_count_reg;
    logic [IDX_W-1:0]              block_index_reg;
    logic                          last_of_block_reg;
    logic                          end_of_data_reg;

    logic [CW-1:0]          blk_w, hop_w, b_w, h_w;
    logic [CNT_W-1:0]       eff_b, eff_h;
    logic                   full;
    logic [AW-1:0]          bs_a;
    logic [CNT_W-1:0]       fill_a, fill_p, real_f, adv_f;
    logic                   is_push, push_go, flush_go, go;
    logic                   load2;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // registers clamped to 1..MAX_BLOCK and 1..block length
    assign blk_w = CW'(blk_len_reg);
    assign hop_w = CW'(hop_len_reg);
    assign b_w   = (blk_w == '0) ? CW'(1)
                 : ((blk_w > CW'(MAX_BLOCK)) ? CW'(MAX_BLOCK) : blk_w);
    assign h_w   = (hop_w == '0) ? CW'(1) : ((hop_w > b_w) ? b_w : hop_w);
    assign eff_b = CNT_W'(b_w);
    assign eff_h = CNT_W'(h_w);

    // a push into a full store drops the oldest sample
    assign is_push  = (cmd == CMD_PUSH);
    assign full     = (fill_reg == MAX_CNT);
    assign bs_a     = full ? ring_add(bs_reg, CNT_W'(1)) : bs_reg;
    assign fill_a   = full ? (MAX_CNT - CNT_W'(1)) : fill_reg;
    assign fill_p   = fill_a + CNT_W'(1);
    assign push_go  = (fill_p >= eff_b);
    assign real_f   = (fill_reg < eff_b) ? fill_reg : eff_b;
    assign adv_f    = (real_f < eff_h) ? real_f : eff_h;
    assign flush_go = (fill_reg != '0);
    assign go       = is_push ? push_go : flush_go;

    assign load2 = !out_valid_reg || !out_stall;

    assign sts.block_go   = go;
    assign sts.slot_free  = !s1_valid_reg || load2;
    assign sts.issue_last = (pos_cnt_reg == (len_reg - CNT_W'(1)));

    always_comb
    begin
        blk_len_next  = blk_len_reg;
        hop_len_next  = hop_len_reg;
        wp_next       = wp_reg;
        bs_next       = bs_reg;
        rd_ptr_next   = rd_ptr_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        real_next     = real_reg;
        pos_cnt_next  = pos_cnt_reg;
        final_next    = final_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_LENGTH: blk_len_next = cfg_data;
                REG_HOP_LENGTH:   hop_len_next = cfg_data;
            endcase
        end

        if (ctl.take)
        begin
            if (is_push)
            begin
                wp_next = ring_add(wp_reg, CNT_W'(1));
                if (push_go)
                begin
                    fill_next = fill_p - eff_h;
                    bs_next   = ring_add(bs_a, eff_h);
                end
                else
                begin
                    fill_next = fill_p;
                    bs_next   = bs_a;
                end
            end
            else if (flush_go)
            begin
                fill_next = fill_reg - adv_f;
                bs_next   = ring_add(bs_reg, adv_f);
            end

            // block state is committed up front, the readout walks from the old start
            if (go)
            begin
                rd_ptr_next  = is_push ? bs_a : bs_reg;
                len_next     = eff_b;
                real_next    = is_push ? eff_b : real_f;
                final_next   = !is_push && (fill_reg == adv_f);
                idx_next     = cnt_reg;
                cnt_next     = cnt_reg + IDX_W'(1);
                pos_cnt_next = '0;
            end
        end

        if (ctl.issue)
        begin
            rd_ptr_next  = ring_add(rd_ptr_reg, CNT_W'(1));
            pos_cnt_next = pos_cnt_reg + CNT_W'(1);
        end

        if (ctl.issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (load2)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_len_reg   <= BLOCK_LENGTH_RST;
            hop_len_reg   <= HOP_LENGTH_RST;
            wp_reg        <= '0;
            bs_reg        <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            len_reg       <= '0;
            real_reg      <= '0;
            pos_cnt_reg   <= '0;
            final_reg     <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            blk_len_reg  <= blk_len_next;
            hop_len_reg  <= hop_len_next;
            wp_reg       <= wp_next;
            bs_reg       <= bs_next;
            rd_ptr_reg   <= rd_ptr_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            real_reg     <= real_next;
            pos_cnt_reg  <= pos_cnt_next;
            final_reg    <= final_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
            if (load2)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // tags that travel alongside the ram read
    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            s1_pos_reg  <= pos_cnt_reg;
            s1_real_reg <= real_reg;
            s1_idx_reg  <= idx_reg;
            s1_pad_reg  <= (pos_cnt_reg >= real_reg);
            s1_last_reg <= sts.issue_last;
            s1_eod_reg  <= sts.issue_last && final_reg;
        end
        if (load2 && s1_valid_reg)
        begin
            sample_out_reg    <= s1_pad_reg ? '0 : ram_rdata;
            position_reg      <= POS_W'(s1_pos_reg);
            real_count_reg    <= REAL_W'(s1_real_reg);
            block_index_reg   <= s1_idx_reg;
            last_of_block_reg <= s1_last_reg;
            end_of_data_reg   <= s1_eod_reg;
        end
    end

    ofb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_BLOCK)
    ) u_ring (
        .clk   (clk),
        .we    (ctl.take && is_push),
        .waddr (wp_reg),
        .wdata (sample_in),
        .re    (ctl.issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign position      = position_reg;
    assign real_count    = real_count_reg;
    assign block_index   = block_index_reg;
    assign last_of_block = last_of_block_reg;
    assign end_of_data   = end_of_data_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= MAX_CNT)
        else $error("fill count beyond ring depth");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.issue |-> (!s1_valid_reg || load2))
        else $error("read issued over an unconsumed read");

    a_eod_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_eod_reg) |-> s1_last_reg)
        else $error("end of data away from block end");

endmodule

`default_nettype wire

// ===== sim/overlapping_block_framer_test.sv =====
// self-checking testbench for the overlapping block framer
`timescale 1ns / 1ps

module overlapping_block_framer_test;
    import ofb_pkg::*;

    localparam int RING_DEPTH = DEF_MAX_BLOCK;
    localparam int SMP_W      = DEF_SAMPLE_BITS;
    localparam int MAX_SHOWN  = 40;

    typedef struct packed {
        logic                    cmd;
        logic signed [SMP_W-1:0] sample;
    } stream_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic [POS_W-1:0]        pos;
        logic [REAL_W-1:0]       real_cnt;
        logic [IDX_W-1:0]        blk;
        logic                    last;
        logic                    eod;
    } block_sample_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = REG_BLOCK_LENGTH;
    logic [CFG_W-1:0]        cfg_data      = '0;
    logic                    in_valid      = 1'b0;
    logic                    in_stall;
    logic                    cmd           = CMD_PUSH;
    logic signed [SMP_W-1:0] sample_in     = '0;
    logic                    out_valid;
    logic                    out_stall     = 1'b0;
    logic signed [SMP_W-1:0] sample_out;
    logic [POS_W-1:0]        position;
    logic [REAL_W-1:0]       real_count;
    logic [IDX_W-1:0]        block_index;
    logic                    last_of_block;
    logic                    end_of_data;

    overlapping_block_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .sample_in     (sample_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .position      (position),
        .real_count    (real_count),
        .block_index   (block_index),
        .last_of_block (last_of_block),
        .end_of_data   (end_of_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // framer model state
    logic [SMP_W-1:0]  ring_mem [RING_DEPTH];
    logic [POS_W-1:0]  wr_ptr    = '0;
    logic [POS_W-1:0]  start_ptr = '0;
    logic [REAL_W-1:0] held      = '0;
    logic [IDX_W-1:0]  blk_count = '0;
    logic [CFG_W-1:0]  cfg_block = BLOCK_LENGTH_RST;
    logic [CFG_W-1:0]  cfg_hop   = HOP_LENGTH_RST;

    stream_item_t  pending_items [$];
    block_sample_t expected_samples [$];
    int            mismatches = 0;

    task automatic emit_block(input int len, input int real_n, input logic tail_end);
        block_sample_t e;
        for (int i = 0; i < len; i++)
        begin
            e.sample   = (i < real_n) ? ring_mem[(start_ptr + i) % RING_DEPTH] : '0;
            e.pos      = POS_W'(i);
            e.real_cnt = REAL_W'(real_n);
            e.blk      = blk_count;
            e.last     = (i == len - 1);
            e.eod      = tail_end && (i == len - 1);
            expected_samples.push_back(e);
        end
    endtask

    task automatic frame_item(input logic c, input logic signed [SMP_W-1:0] s);
        int b;
        int h;
        int real_n;
        int adv;
        b = cfg_block;
        if (b < 1) b = 1;
        if (b > RING_DEPTH) b = RING_DEPTH;
        h = cfg_hop;
        if (h < 1) h = 1;
        if (h > b) h = b;
        if (c == CMD_PUSH)
        begin
            // store overflow drops the oldest sample
            if (held >= RING_DEPTH)
            begin
                start_ptr = start_ptr + 1'b1;
                held      = REAL_W'(RING_DEPTH - 1);
            end
            ring_mem[wr_ptr] = s;
            wr_ptr = wr_ptr + 1'b1;
            held   = held + 1'b1;
            if (held >= b)
            begin
                emit_block(b, b, 1'b0);
                start_ptr = start_ptr + POS_W'(h);
                held      = held - REAL_W'(h);
                blk_count = blk_count + 1'b1;
            end
        end
        else if (held != 0)
        begin
            real_n = (held < b) ? held : b;
            adv    = (real_n < h) ? real_n : h;
            emit_block(b, real_n, held == adv);
            start_ptr = start_ptr + POS_W'(adv);
            held      = held - REAL_W'(adv);
            blk_count = blk_count + 1'b1;
        end
    endtask

    // sender: bursts with random gaps
    stream_item_t nxt;
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                frame_item(cmd, sample_in);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    in_valid  <= 1'b1;
                    cmd       <= nxt.cmd;
                    sample_in <= nxt.sample;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each output transfer and switches among four stall pattern modes
    block_sample_t got;
    block_sample_t want;
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{sample_out, position, real_count, block_index,
                        last_of_block, end_of_data};
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected transfer sample %0d pos %0d block %0d",
                                 $time, got.sample, got.pos, got.blk);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"%0t: expected sample %0d pos %0d real %0d block %0d ",
                                      "last %b end %b, actual sample %0d pos %0d real %0d ",
                                      "block %0d last %b end %b"},
                                     $time, want.sample, want.pos, want.real_cnt, want.blk,
                                     want.last, want.eod, got.sample, got.pos, got.real_cnt,
                                     got.blk, got.last, got.eod);
                    end
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(32, 200);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    function automatic void add_item(input logic c, input logic signed [SMP_W-1:0] s);
        pending_items.push_back('{c, s});
    endfunction

    // wait until the sender has drained and every block has come out
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_lengths(input logic [CFG_W-1:0] blen, input logic [CFG_W-1:0] hlen);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BLOCK_LENGTH;
        cfg_data  <= blen;
        @(posedge clk);
        cfg_index <= REG_HOP_LENGTH;
        cfg_data  <= hlen;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_block = blen;
        cfg_hop   = hlen;
        @(negedge clk);
    endtask

    initial
    begin
        int n;
        logic [CFG_W-1:0] blen;
        logic [CFG_W-1:0] hlen;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset lengths: flush on empty store is ignored, then a mostly padded tail
        add_item(CMD_FLUSH, 16'sh1234);
        add_item(CMD_PUSH, 16'sh7fff);
        add_item(CMD_PUSH, -16'sh8000);
        add_item(CMD_PUSH, 16'sh0001);
        add_item(CMD_FLUSH, 16'sh0000);
        wait_drained();

        set_lengths(7'd4, 7'd2);
        add_item(CMD_PUSH, -16'sh0001);
        add_item(CMD_PUSH, 16'sh0000);
        add_item(CMD_PUSH, 16'sh7fff);
        add_item(CMD_PUSH, -16'sh8000);
        add_item(CMD_PUSH, 16'sh5555);
        add_item(CMD_PUSH, -16'sh5556);
        add_item(CMD_FLUSH, -16'sh0001);
        add_item(CMD_FLUSH, 16'sh0000);
        wait_drained();

        // zero lengths clamp to one sample per block
        set_lengths(7'd0, 7'd0);
        add_item(CMD_PUSH, 16'sh0f0f);
        add_item(CMD_PUSH, -16'sh0f10);
        add_item(CMD_FLUSH, 16'sh0000);
        wait_drained();

        set_lengths(7'd6, 7'd1);
        for (int i = 0; i < 6; i++)
            add_item(CMD_PUSH, SMP_W'($urandom));
        wait_drained();

        // shorter block with more held than a block: flush without padding, hop clamped
        set_lengths(7'd2, 7'd127);
        add_item(CMD_FLUSH, 16'sh0000);
        add_item(CMD_PUSH, SMP_W'($urandom));
        add_item(CMD_FLUSH, 16'sh0000);
        wait_drained();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: begin blen = 7'd64;  hlen = 7'd16;  end
                1: begin blen = 7'd127; hlen = 7'd127; end
                2: begin blen = 7'd1;   hlen = 7'd1;   end
                3: begin blen = 7'd64;  hlen = 7'd1;   end
                4: begin blen = 7'd100; hlen = 7'd0;   end
                5: begin blen = 7'd3;   hlen = 7'd5;   end
                6:
                begin
                    blen = CFG_W'($urandom);
                    hlen = CFG_W'($urandom);
                end
                default:
                begin
                    blen = CFG_W'($urandom_range(1, RING_DEPTH));
                    hlen = CFG_W'($urandom_range(1, blen));
                end
            endcase
            set_lengths(blen, hlen);
            n = $urandom_range(15, 24);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    add_item(CMD_FLUSH, SMP_W'($urandom));
                else
                    add_item(CMD_PUSH, SMP_W'($urandom));
            end
            // end of stream tail for about half the phases
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 4)) add_item(CMD_FLUSH, SMP_W'($urandom));
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
